// ===== sv/eicb_pkg.sv =====
// shared types and constants for the edge interval capture block
// no dependencies; used by every module of the block
`default_nettype none

package eicb_pkg;

   localparam int COUNT_WIDTH_DEF = 16;

   localparam int BLANK_WIDTH   = 16;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int LIMIT_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DAT_WIDTH = 16;
   localparam int US_WIDTH      = 15;

   localparam logic [BLANK_WIDTH-1:0]   BLANK_RESET   = 16'd200;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd5000;
   localparam logic [LIMIT_WIDTH-1:0]   LIMIT_RESET   = 8'd5;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BLANK   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LIMIT   = 2'd2;

   // request modes
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_DISABLE = 2'd1;
   localparam logic [1:0] MODE_ENABLE  = 2'd2;

   // result kinds
   localparam logic EV_INTERVAL = 1'b0;
   localparam logic EV_RESET    = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic       level;
   } req_type;

   typedef struct packed {
      logic                event_kind;
      logic [US_WIDTH-1:0] interval_us;
      logic                new_level;
      logic                inhibit_transmit;
   } rsp_type;

   typedef struct packed {
      logic [BLANK_WIDTH-1:0]   blank_ticks;
      logic [TIMEOUT_WIDTH-1:0] timeout_ticks;
      logic [LIMIT_WIDTH-1:0]   pulse_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/eicb_csr.sv =====
// configuration registers: blanking length, timeout and pulse limit
// depends on eicb_pkg
`default_nettype none

module eicb_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [eicb_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [eicb_pkg::CSR_DAT_WIDTH-1:0]  csr_wdata,
   output eicb_pkg::cfg_type                        cfg
);

   eicb_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blank_ticks   <= eicb_pkg::BLANK_RESET;
         cfg_ff.timeout_ticks <= eicb_pkg::TIMEOUT_RESET;
         cfg_ff.pulse_limit   <= eicb_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            eicb_pkg::CSR_BLANK: begin
               cfg_ff.blank_ticks <= csr_wdata[eicb_pkg::BLANK_WIDTH-1:0];
            end
            eicb_pkg::CSR_TIMEOUT: begin
               cfg_ff.timeout_ticks <= csr_wdata[eicb_pkg::TIMEOUT_WIDTH-1:0];
            end
            eicb_pkg::CSR_LIMIT: begin
               cfg_ff.pulse_limit <= csr_wdata[eicb_pkg::LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/eicb_tracker.sv =====
// edge tracking state machine: phase, tick counter, pulse count, inhibit
// depends on eicb_pkg; produces at most one result per accepted request
`default_nettype none

module eicb_tracker #(
   parameter int COUNT_WIDTH = eicb_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire eicb_pkg::req_type  req_item,
   input  wire eicb_pkg::cfg_type  cfg,
   output logic                    res_valid,
   output eicb_pkg::rsp_type       res_item
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ARMED = 2'd1,
      PH_BLANK = 2'd2,
      PH_WAIT  = 2'd3
   } phase_type;

   localparam logic [eicb_pkg::LIMIT_WIDTH-1:0] COUNT_MAX = '1;

   phase_type                           phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]              ticks_ff, ticks_in;
   logic                                prev_ff, prev_in;
   logic [eicb_pkg::LIMIT_WIDTH-1:0]    count_ff, count_in;
   logic                                flag_ff, flag_in;

   logic                                change;
   logic [COUNT_WIDTH-1:0]              t_inc;
   logic [31:0]                         t_wide;
   logic [eicb_pkg::US_WIDTH-1:0]       us;

   always_comb begin
      change = (req_item.level != prev_ff);
      t_inc  = (ticks_ff == '1) ? ticks_ff : ticks_ff + COUNT_WIDTH'(1);
      t_wide = 32'(t_inc);
      // halve and saturate at the field maximum
      if (|t_wide[31:eicb_pkg::US_WIDTH+1]) begin
         us = '1;
      end else begin
         us = t_wide[eicb_pkg::US_WIDTH:1];
      end

      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      flag_in   = flag_ff;
      res_valid = 1'b0;
      res_item  = '{event_kind: eicb_pkg::EV_RESET, interval_us: '0,
                    new_level: 1'b0, inhibit_transmit: 1'b0};

      case (req_item.mode)
         eicb_pkg::MODE_DISABLE: begin
            if (phase_ff != PH_IDLE) begin
               res_valid = 1'b1;
               phase_in  = PH_IDLE;
               ticks_in  = '0;
               count_in  = '0;
               flag_in   = 1'b0;
            end
         end
         eicb_pkg::MODE_ENABLE: begin
            phase_in = PH_ARMED;
            ticks_in = '0;
         end
         eicb_pkg::MODE_TICK: begin
            prev_in = req_item.level;
            case (phase_ff)
               PH_ARMED: begin
                  if (change && req_item.level) begin
                     ticks_in = '0;
                     phase_in = PH_BLANK;
                  end
               end
               PH_BLANK: begin
                  ticks_in = t_inc;
                  if (change) begin
                     // glitch inside blanking
                     res_valid = 1'b1;
                     phase_in  = PH_ARMED;
                     ticks_in  = '0;
                     count_in  = '0;
                     flag_in   = 1'b0;
                  end else if (t_wide >= 32'(cfg.blank_ticks)) begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  ticks_in = t_inc;
                  if (change) begin
                     count_in = (count_ff == COUNT_MAX) ? count_ff
                                : count_ff + eicb_pkg::LIMIT_WIDTH'(1);
                     flag_in  = flag_ff | (count_in >= cfg.pulse_limit);
                     ticks_in = '0;
                     phase_in = PH_BLANK;
                     res_valid = 1'b1;
                     res_item  = '{event_kind: eicb_pkg::EV_INTERVAL, interval_us: us,
                                   new_level: req_item.level, inhibit_transmit: flag_in};
                  end else if (t_wide >= 32'(cfg.timeout_ticks)) begin
                     res_valid = 1'b1;
                     phase_in  = PH_ARMED;
                     ticks_in  = '0;
                     count_in  = '0;
                     flag_in   = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ARMED;
         ticks_ff <= '0;
         prev_ff  <= 1'b0;
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/eicb_out.sv =====
// result register with one skid entry behind it
// depends on eicb_pkg; stall toward the request side comes from a register
`default_nettype none

module eicb_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               res_valid,
   input  wire eicb_pkg::rsp_type  res_item,
   output logic                    hold,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output eicb_pkg::rsp_type       rsp_item
);

   logic              out_valid_ff;
   eicb_pkg::rsp_type out_ff;
   logic              skid_valid_ff;
   eicb_pkg::rsp_type skid_ff;
   logic              out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no new results while the skid entry is full
         if (out_take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff       <= res_item;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res_item;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign hold      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

`default_nettype wire

// ===== sv/edge_interval_capture_with_blanking_core.sv =====
// Edge interval capture with blanking and timeout. One request is taken per
// clock cycle unless stalled: each request (a tick with its sampled level,
// or an enable or disable command) is evaluated combinationally against the
// tracker state; its result, if any, is registered into the result register
// or, while that register is stalled, into the one-entry skid buffer, which
// lets requests keep flowing while a result waits; req_stall rises only
// once it is full. Intervals are in microseconds (ticks halved, saturated).
// Configuration writes are always ready and should only be made while idle.
// Depends on eicb_pkg, eicb_csr, eicb_tracker and eicb_out.
`default_nettype none

module edge_interval_capture_with_blanking_core #(
   parameter int COUNT_WIDTH = eicb_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire eicb_pkg::req_type                   req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output eicb_pkg::rsp_type                        rsp_item,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [eicb_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [eicb_pkg::CSR_DAT_WIDTH-1:0]  csr_wdata
);

   eicb_pkg::cfg_type cfg;
   eicb_pkg::rsp_type res_item;
   logic              res_valid;
   logic              req_accept;
   logic              hold;

   assign csr_ready  = 1'b1;
   assign req_stall  = hold;
   assign req_accept = req_valid && !hold;

   eicb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eicb_tracker #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_item),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res_item   (res_item)
   );

   eicb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid && req_accept),
      .res_item  (res_item),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== sv/eicb_checker.sv =====
// port-level checks for the edge interval capture block, bound to the top
// depends on eicb_pkg and edge_interval_capture_with_blanking_core
`default_nettype none

module eicb_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire eicb_pkg::rsp_type  rsp_item
);

   // a reset event carries no measurement
   a_reset_event_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.event_kind == eicb_pkg::EV_RESET |->
      rsp_item.interval_us == '0 && !rsp_item.new_level && !rsp_item.inhibit_transmit)
      else $error("reset event with nonzero fields");

   // stall upstream only while a result is already waiting downstream
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty result register");

   // nothing pending right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result pending after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

endmodule

bind edge_interval_capture_with_blanking_core eicb_checker u_eicb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire
